[rtl/core/cluster_label_table_unit_assert.svh]
// Assertion macros shared by the cluster label table RTL.
`ifndef CLUSTER_LABEL_TABLE_UNIT_ASSERT_SVH
`define CLUSTER_LABEL_TABLE_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define CLT_ASSERT_HOLDS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define CLT_ASSERT_THEN(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/clt_pkg.sv]
// Shared types and constants of the cluster label table.
`default_nettype none

package clt_pkg;

	localparam int MAX_OBJECTS = 64;
	localparam int LABEL_W     = 6;
	localparam int COUNT_W     = 7;
	localparam int CMD_W       = 3;
	localparam int STAT_W      = 3;
	localparam int LRAM_AW     = LABEL_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 3'd0,
		CMD_REBUILD = 3'd1,
		CMD_MOVE    = 3'd2,
		CMD_PROPOSE = 3'd3,
		CMD_QUERY   = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_OBJ   = 3'd1,
		STAT_BAD_LABEL = 3'd2,
		STAT_STALE     = 3'd3,
		STAT_NO_FREE   = 3'd4
	} stat_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [LABEL_W-1:0] object_index;
		logic [LABEL_W-1:0] new_label;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [LABEL_W-1:0] object_label;
		logic [LABEL_W-1:0] cluster_slot;
		logic [COUNT_W-1:0] cluster_size;
		logic [COUNT_W-1:0] cluster_total;
		logic [LABEL_W-1:0] fresh_label;
	} rsp_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [COUNT_W-1:0] size;
	} slot_t;

endpackage

`default_nettype wire

[rtl/core/clt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module clt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/cluster_label_table_unit.sv]
// Top level of the cluster label table: command sequencer around two RAMs.
`default_nettype none
`include "cluster_label_table_unit_assert.svh"

// Usage
//   req / req_valid / req_ready carries one command beat; rsp / rsp_valid / rsp_ready
//   returns exactly one result beat per command, in order.
//   cfg_we with cfg_wdata sets the object count (0 reads as 1, above 64 as 64) and
//   restores the one-cluster table; write it only while no command is in flight.
// Each command is sequenced around the single read port of each RAM (one read per
// cycle, registered read data, every update a read-modify-write). A rebuild walks
// every object; propose scans the label-in-use flags, plus a rebuild when the table
// is stale. Commands are taken one at a time.
// The label RAM holds object labels in its lower half and the label-to-slot map in
// its upper half; the slot RAM holds label and size per slot. Per-object and
// per-label flags in flip-flops stand for the never-written entries.
// Reset: 64 objects, all labelled 0, one slot; a table set-up state follows reset
// and every configuration write, with req_ready low.
// Stall: a finished result waits in the output register; a new command is still
// accepted, and its own result waits until the held beat is taken.
module cluster_label_table_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output      logic                            req_ready,
	input  wire clt_pkg::req_t                   req,
	output      logic                            rsp_valid,
	input  wire logic                            rsp_ready,
	output      clt_pkg::rsp_t                   rsp,
	input  wire logic                            cfg_we,
	input  wire logic [clt_pkg::COUNT_W-1:0]     cfg_wdata
);

	import clt_pkg::*;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE,
		S_RB_START, S_RB_RD, S_RB_LAB, S_RB_MAP, S_RB_SZ, S_RB_END,
		S_OBJ_RD, S_OBJ_DATA,
		S_LK_RD, S_LK_MAP, S_LK_SZ,
		S_MV_NS, S_MV_OS, S_MV_WOBJ, S_MV_APP, S_MV_INC, S_MV_DEC_RD, S_MV_DEC, S_MV_LAST,
		S_PROP_START, S_PROP_SCAN, S_PROP_END,
		S_DONE
	} state_t;

	localparam logic [COUNT_W-1:0]     MAX_CNT      = COUNT_W'(MAX_OBJECTS);
	localparam logic [MAX_OBJECTS-1:0] PRESENT_INIT = MAX_OBJECTS'(1);
	localparam logic [LABEL_W-1:0]     LAST_IDX     = LABEL_W'(MAX_OBJECTS - 1);

	state_t                state_q;
	logic [COUNT_W-1:0]    n_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  current_q;
	logic [MAX_OBJECTS-1:0] ovalid_q;
	logic [MAX_OBJECTS-1:0] present_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [LABEL_W-1:0]    obj_q;
	logic [LABEL_W-1:0]    new_q;
	logic                  obj_ok_q;
	logic                  lab_ok_q;
	logic [LABEL_W-1:0]    lab_q;
	logic [LABEL_W-1:0]    look_q;
	logic [LABEL_W-1:0]    ns_q;
	logic [LABEL_W-1:0]    os_q;
	logic [LABEL_W-1:0]    idx_q;
	logic [LABEL_W-1:0]    top_q;
	logic [LABEL_W-1:0]    gap_q;
	logic                  gap_found_q;

	stat_t                 res_status_q;
	logic [LABEL_W-1:0]    res_label_q;
	logic [LABEL_W-1:0]    res_slot_q;
	logic [COUNT_W-1:0]    res_size_q;
	logic [LABEL_W-1:0]    res_fresh_q;

	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	// RAM ports
	logic                  lr_we;
	logic [LRAM_AW-1:0]    lr_waddr;
	logic [LABEL_W-1:0]    lr_wdata;
	logic [LRAM_AW-1:0]    lr_raddr;
	logic [LABEL_W-1:0]    lr_rdata;
	logic                  sr_we;
	logic [LABEL_W-1:0]    sr_waddr;
	slot_t                 sr_wdata;
	logic [LABEL_W-1:0]    sr_raddr;
	slot_t                 sr_rdata;
	logic [$bits(slot_t)-1:0] sr_rdata_raw;

	logic [LABEL_W-1:0]    rb_lab;
	logic [LABEL_W-1:0]    cur_lab;
	logic                  rb_last;
	logic                  req_obj_ok;
	logic                  req_lab_ok;
	logic                  dec_zero;
	logic [COUNT_W-1:0]    cfg_n;
	logic [COUNT_W-1:0]    top_inc;
	logic [COUNT_W-1:0]    count_dec;

	clt_ram #(.WIDTH(LABEL_W), .DEPTH(2 * MAX_OBJECTS)) u_label_ram (
		.clk   (clk),
		.we    (lr_we),
		.waddr (lr_waddr),
		.wdata (lr_wdata),
		.raddr (lr_raddr),
		.rdata (lr_rdata)
	);

	clt_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_OBJECTS)) u_slot_ram (
		.clk   (clk),
		.we    (sr_we),
		.waddr (sr_waddr),
		.wdata (sr_wdata),
		.raddr (sr_raddr),
		.rdata (sr_rdata_raw)
	);

	assign sr_rdata  = slot_t'(sr_rdata_raw);
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Never-written object entries read as label 0
	assign rb_lab     = ovalid_q[idx_q] ? lr_rdata : '0;
	assign cur_lab    = ovalid_q[obj_q] ? lr_rdata : '0;
	assign rb_last    = ({1'b0, idx_q} + COUNT_W'(1)) >= n_q;
	assign req_obj_ok = {1'b0, req.object_index} < n_q;
	assign req_lab_ok = {1'b0, req.new_label} < n_q;
	assign dec_zero   = (sr_rdata.size == COUNT_W'(1));
	assign top_inc    = {1'b0, top_q} + COUNT_W'(1);
	assign count_dec  = count_q - COUNT_W'(1);
	assign cfg_n      = (cfg_wdata == '0) ? COUNT_W'(1) :
	                    (cfg_wdata > MAX_CNT) ? MAX_CNT : cfg_wdata;

	// RAM addressing per sequencer step
	always_comb begin
		lr_we    = 1'b0;
		lr_waddr = '0;
		lr_wdata = '0;
		lr_raddr = '0;
		sr_we    = 1'b0;
		sr_waddr = '0;
		sr_wdata = '0;
		sr_raddr = '0;
		unique case (state_q)
			S_INIT: begin
				lr_we    = 1'b1;
				lr_waddr = {1'b1, LABEL_W'(0)};
				sr_we    = 1'b1;
				sr_wdata = '{label: '0, size: n_q};
			end
			S_RB_RD: lr_raddr = {1'b0, idx_q};
			S_RB_LAB: begin
				if (present_q[rb_lab]) begin
					lr_raddr = {1'b1, rb_lab};
				end else if (count_q < MAX_CNT) begin
					lr_we    = 1'b1;
					lr_waddr = {1'b1, rb_lab};
					lr_wdata = count_q[LABEL_W-1:0];
					sr_we    = 1'b1;
					sr_waddr = count_q[LABEL_W-1:0];
					sr_wdata = '{label: rb_lab, size: COUNT_W'(1)};
				end
			end
			S_RB_MAP: sr_raddr = lr_rdata;
			S_RB_SZ: begin
				sr_we    = 1'b1;
				sr_waddr = ns_q;
				sr_wdata = '{label: sr_rdata.label, size: sr_rdata.size + COUNT_W'(1)};
			end
			S_OBJ_RD: lr_raddr = {1'b0, obj_q};
			S_OBJ_DATA: begin
				if (cmd_q == CMD_WRITE && lab_ok_q) begin
					lr_we    = 1'b1;
					lr_waddr = {1'b0, obj_q};
					lr_wdata = new_q;
				end
			end
			S_LK_RD: lr_raddr = {1'b1, look_q};
			S_LK_MAP: sr_raddr = lr_rdata;
			S_MV_NS: lr_raddr = {1'b1, new_q};
			S_MV_OS: lr_raddr = {1'b1, lab_q};
			S_MV_WOBJ: begin
				lr_we    = 1'b1;
				lr_waddr = {1'b0, obj_q};
				lr_wdata = new_q;
				sr_raddr = ns_q;
			end
			S_MV_APP: begin
				if (count_q < MAX_CNT) begin
					lr_we    = 1'b1;
					lr_waddr = {1'b1, new_q};
					lr_wdata = count_q[LABEL_W-1:0];
					sr_we    = 1'b1;
					sr_waddr = count_q[LABEL_W-1:0];
					sr_wdata = '{label: new_q, size: COUNT_W'(1)};
				end
			end
			S_MV_INC: begin
				sr_we    = 1'b1;
				sr_waddr = ns_q;
				sr_wdata = '{label: sr_rdata.label, size: sr_rdata.size + COUNT_W'(1)};
			end
			S_MV_DEC_RD: sr_raddr = os_q;
			S_MV_DEC: begin
				if (sr_rdata.size != '0 && !dec_zero) begin
					sr_we    = 1'b1;
					sr_waddr = os_q;
					sr_wdata = '{label: sr_rdata.label, size: sr_rdata.size - COUNT_W'(1)};
				end else begin
					sr_raddr = count_dec[LABEL_W-1:0];
				end
			end
			S_MV_LAST: begin
				// fill the emptied slot with the last one and repoint its label
				sr_we    = 1'b1;
				sr_waddr = os_q;
				sr_wdata = sr_rdata;
				lr_we    = 1'b1;
				lr_waddr = {1'b1, sr_rdata.label};
				lr_wdata = os_q;
			end
			default: ;
		endcase
	end

	// Sequencer, table registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			n_q          <= MAX_CNT;
			count_q      <= COUNT_W'(1);
			current_q    <= 1'b1;
			ovalid_q     <= '0;
			present_q    <= PRESENT_INIT;
			cmd_q        <= '0;
			obj_q        <= '0;
			new_q        <= '0;
			obj_ok_q     <= 1'b0;
			lab_ok_q     <= 1'b0;
			lab_q        <= '0;
			look_q       <= '0;
			ns_q         <= '0;
			os_q         <= '0;
			idx_q        <= '0;
			top_q        <= '0;
			gap_q        <= '0;
			gap_found_q  <= 1'b0;
			res_status_q <= STAT_OK;
			res_label_q  <= '0;
			res_slot_q   <= '0;
			res_size_q   <= '0;
			res_fresh_q  <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// drop the taken beat unless a new one replaces it this cycle
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				n_q       <= cfg_n;
				ovalid_q  <= '0;
				present_q <= PRESENT_INIT;
				count_q   <= COUNT_W'(1);
				current_q <= 1'b1;
				state_q   <= S_INIT;
			end else begin
				unique case (state_q)
					S_INIT: state_q <= S_IDLE;
					S_IDLE: begin
						if (req_valid) begin
							cmd_q        <= req.command;
							obj_q        <= req.object_index;
							new_q        <= req.new_label;
							obj_ok_q     <= req_obj_ok;
							lab_ok_q     <= req_lab_ok;
							res_status_q <= STAT_OK;
							res_label_q  <= '0;
							res_slot_q   <= '0;
							res_size_q   <= '0;
							res_fresh_q  <= '0;
							unique case (req.command)
								CMD_WRITE, CMD_MOVE: begin
									if (req_obj_ok) begin
										state_q <= S_OBJ_RD;
									end else begin
										res_status_q <= STAT_BAD_OBJ;
										state_q      <= S_DONE;
									end
								end
								CMD_REBUILD: state_q <= S_RB_START;
								CMD_PROPOSE: state_q <= current_q ? S_PROP_START : S_RB_START;
								CMD_QUERY: begin
									if (!current_q) begin
										state_q <= S_RB_START;
									end else if (req_obj_ok) begin
										state_q <= S_OBJ_RD;
									end else begin
										res_status_q <= STAT_BAD_OBJ;
										state_q      <= S_DONE;
									end
								end
								default: state_q <= S_DONE;
							endcase
						end
					end
					S_RB_START: begin
						present_q <= '0;
						count_q   <= '0;
						idx_q     <= '0;
						state_q   <= S_RB_RD;
					end
					S_RB_RD: state_q <= S_RB_LAB;
					S_RB_LAB: begin
						if (present_q[rb_lab]) begin
							state_q <= S_RB_MAP;
						end else begin
							if (count_q < MAX_CNT) begin
								present_q[rb_lab] <= 1'b1;
								count_q           <= count_q + COUNT_W'(1);
							end
							idx_q   <= idx_q + LABEL_W'(1);
							state_q <= rb_last ? S_RB_END : S_RB_RD;
						end
					end
					S_RB_MAP: begin
						ns_q    <= lr_rdata;
						state_q <= S_RB_SZ;
					end
					S_RB_SZ: begin
						idx_q   <= idx_q + LABEL_W'(1);
						state_q <= rb_last ? S_RB_END : S_RB_RD;
					end
					S_RB_END: begin
						current_q <= 1'b1;
						priority if (cmd_q == CMD_PROPOSE) begin
							state_q <= S_PROP_START;
						end else if (cmd_q == CMD_QUERY && obj_ok_q) begin
							state_q <= S_OBJ_RD;
						end else if (cmd_q == CMD_QUERY) begin
							res_status_q <= STAT_BAD_OBJ;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_OBJ_RD: state_q <= S_OBJ_DATA;
					S_OBJ_DATA: begin
						lab_q       <= cur_lab;
						res_label_q <= cur_lab;
						look_q      <= cur_lab;
						priority if (cmd_q == CMD_WRITE) begin
							if (lab_ok_q) begin
								ovalid_q[obj_q] <= 1'b1;
								current_q       <= 1'b0;
								res_label_q     <= new_q;
							end else begin
								res_status_q <= STAT_BAD_LABEL;
							end
							state_q <= S_DONE;
						end else if (cmd_q == CMD_MOVE) begin
							if (!lab_ok_q) begin
								res_status_q <= STAT_BAD_LABEL;
								state_q      <= S_DONE;
							end else if (!current_q) begin
								res_status_q <= STAT_STALE;
								state_q      <= S_DONE;
							end else begin
								res_label_q <= new_q;
								look_q      <= new_q;
								state_q     <= (cur_lab == new_q) ? S_LK_RD : S_MV_NS;
							end
						end else begin
							state_q <= S_LK_RD;
						end
					end
					S_LK_RD: state_q <= S_LK_MAP;
					S_LK_MAP: begin
						if (present_q[look_q]) begin
							res_slot_q <= lr_rdata;
							state_q    <= S_LK_SZ;
						end else begin
							state_q <= S_DONE;
						end
					end
					S_LK_SZ: begin
						res_size_q <= sr_rdata.size;
						state_q    <= S_DONE;
					end
					S_MV_NS: state_q <= S_MV_OS;
					S_MV_OS: begin
						ns_q    <= lr_rdata;
						state_q <= S_MV_WOBJ;
					end
					S_MV_WOBJ: begin
						os_q            <= lr_rdata;
						ovalid_q[obj_q] <= 1'b1;
						state_q         <= present_q[new_q] ? S_MV_INC : S_MV_APP;
					end
					S_MV_APP: begin
						if (count_q < MAX_CNT) begin
							present_q[new_q] <= 1'b1;
							count_q          <= count_q + COUNT_W'(1);
						end
						state_q <= S_MV_DEC_RD;
					end
					S_MV_INC: state_q <= S_MV_DEC_RD;
					S_MV_DEC_RD: state_q <= present_q[lab_q] ? S_MV_DEC : S_LK_RD;
					S_MV_DEC: state_q <= (sr_rdata.size != '0 && dec_zero) ? S_MV_LAST : S_LK_RD;
					S_MV_LAST: begin
						present_q[lab_q] <= 1'b0;
						count_q          <= count_dec;
						state_q          <= S_LK_RD;
					end
					S_PROP_START: begin
						if (count_q >= n_q) begin
							res_status_q <= STAT_NO_FREE;
							state_q      <= S_DONE;
						end else begin
							idx_q       <= '0;
							top_q       <= '0;
							gap_q       <= '0;
							gap_found_q <= 1'b0;
							state_q     <= S_PROP_SCAN;
						end
					end
					S_PROP_SCAN: begin
						// ascending walk: the last used label seen is the largest
						if (present_q[idx_q]) begin
							top_q <= idx_q;
						end else if (!gap_found_q && ({1'b0, idx_q} < n_q)) begin
							gap_q       <= idx_q;
							gap_found_q <= 1'b1;
						end
						idx_q   <= idx_q + LABEL_W'(1);
						state_q <= (idx_q == LAST_IDX) ? S_PROP_END : S_PROP_SCAN;
					end
					S_PROP_END: begin
						priority if (!present_q[0]) begin
							res_fresh_q <= '0;
						end else if (top_inc < n_q) begin
							res_fresh_q <= top_inc[LABEL_W-1:0];
						end else begin
							res_fresh_q <= gap_q;
						end
						state_q <= S_DONE;
					end
					S_DONE: begin
						// hold until the output register is free
						if (!rsp_valid_q || rsp_ready) begin
							rsp_q <= '{status: res_status_q, object_label: res_label_q,
							           cluster_slot: res_slot_q, cluster_size: res_size_q,
							           cluster_total: count_q, fresh_label: res_fresh_q};
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	`CLT_ASSERT_THEN(a_count_matches_flags, state_q == S_IDLE, $countones(present_q) == count_q, "slot count disagrees with label flags")
	`CLT_ASSERT_NEXT(a_cfg_restores_table, cfg_we, state_q == S_INIT && count_q == COUNT_W'(1) && present_q == PRESENT_INIT, "configuration did not restore the table")
	`CLT_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready && !cfg_we, state_q != S_IDLE, "accepted command produced no work")
	`CLT_ASSERT_NEXT(a_done_holds_on_stall, state_q == S_DONE && rsp_valid_q && !rsp_ready && !cfg_we, state_q == S_DONE, "result dropped while output stalled")
	`CLT_ASSERT_THEN(a_total_nonzero, rsp_valid_q, rsp_q.cluster_total != '0, "result reports an empty table")

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the cluster label table unit.
`timescale 1ns / 100ps

module testbench;
	import clt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 600;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;
	logic  cfg_we = 1'b0;
	logic  [COUNT_W-1:0] cfg_wdata = '0;

	// idle percentages for sender and receiver, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// shadow state of the label table
	int unsigned n_objects;
	logic [LABEL_W-1:0] obj_label [MAX_OBJECTS];
	logic [LABEL_W-1:0] tbl_label [MAX_OBJECTS];
	logic [COUNT_W-1:0] tbl_size  [MAX_OBJECTS];
	int unsigned        tbl_count;
	bit                 tbl_current;

	rsp_t pending_rsp [$];
	int   fail_count = 0;
	int   beats_in = 0;
	int   beats_out = 0;
	int   idle_cycles = 0;
	int   status_seen [8];

	cluster_label_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Restore the one-slot table for n objects.
	function automatic void table_init(int unsigned n);
		n_objects = n;
		for (int i = 0; i < MAX_OBJECTS; i++) begin
			obj_label[i] = '0;
			tbl_label[i] = '0;
			tbl_size[i] = '0;
		end
		tbl_size[0] = COUNT_W'(n);
		tbl_count = 1;
		tbl_current = 1'b1;
	endfunction

	// Rebuild slots in order of first appearance.
	function automatic void table_rebuild();
		bit hit;
		for (int i = 0; i < MAX_OBJECTS; i++) begin
			tbl_label[i] = '0;
			tbl_size[i] = '0;
		end
		tbl_label[0] = obj_label[0];
		tbl_size[0] = 1;
		tbl_count = 1;
		for (int i = 1; i < n_objects; i++) begin
			hit = 1'b0;
			for (int j = 0; j < tbl_count; j++) begin
				if (!hit && tbl_label[j] == obj_label[i]) begin
					tbl_size[j]++;
					hit = 1'b1;
				end
			end
			if (!hit && tbl_count < MAX_OBJECTS) begin
				tbl_label[tbl_count] = obj_label[i];
				tbl_size[tbl_count] = 1;
				tbl_count++;
			end
		end
		tbl_current = 1'b1;
	endfunction

	function automatic int unsigned slot_of(logic [LABEL_W-1:0] lab);
		for (int j = 0; j < tbl_count; j++)
			if (tbl_label[j] == lab) return j;
		return tbl_count;
	endfunction

	// Move one object in the current table; an emptied slot takes the last slot.
	function automatic void table_move(int unsigned obj, logic [LABEL_W-1:0] lab);
		logic [LABEL_W-1:0] prev;
		int unsigned os, ns, last;
		prev = obj_label[obj];
		if (prev == lab) return;
		os = slot_of(prev);
		ns = slot_of(lab);
		obj_label[obj] = lab;
		if (ns >= tbl_count) begin
			if (tbl_count < MAX_OBJECTS) begin
				tbl_label[tbl_count] = lab;
				tbl_size[tbl_count] = 1;
				tbl_count++;
			end
		end else begin
			tbl_size[ns]++;
		end
		if (os < tbl_count && tbl_size[os] > 0) begin
			tbl_size[os]--;
			if (tbl_size[os] == 0) begin
				last = tbl_count - 1;
				tbl_label[os] = tbl_label[last];
				tbl_size[os] = tbl_size[last];
				tbl_label[last] = '0;
				tbl_size[last] = '0;
				tbl_count--;
			end
		end
	endfunction

	// Work out the result beat of one command and advance the shadow state.
	function automatic rsp_t label_table_predict(req_t r);
		rsp_t o;
		bit obj_ok, lab_ok, addressed;
		bit used [MAX_OBJECTS];
		int unsigned top, sl;
		o = '0;
		obj_ok = r.object_index < n_objects;
		lab_ok = r.new_label < n_objects;
		addressed = 1'b0;
		sl = 0;
		case (r.command)
			CMD_WRITE: begin
				addressed = 1'b1;
				if (!obj_ok) o.status = STAT_BAD_OBJ;
				else if (!lab_ok) o.status = STAT_BAD_LABEL;
				else begin
					obj_label[r.object_index] = r.new_label;
					tbl_current = 1'b0;
				end
			end
			CMD_REBUILD: table_rebuild();
			CMD_MOVE: begin
				addressed = 1'b1;
				if (!obj_ok) o.status = STAT_BAD_OBJ;
				else if (!lab_ok) o.status = STAT_BAD_LABEL;
				else if (!tbl_current) o.status = STAT_STALE;
				else begin
					table_move(r.object_index, r.new_label);
					sl = slot_of(obj_label[r.object_index]);
					if (sl < tbl_count) o.cluster_size = tbl_size[sl];
					else sl = 0;
					o.cluster_slot = LABEL_W'(sl);
				end
			end
			CMD_PROPOSE: begin
				if (!tbl_current) table_rebuild();
				if (tbl_count >= n_objects) o.status = STAT_NO_FREE;
				else begin
					top = 0;
					for (int j = 0; j < MAX_OBJECTS; j++) used[j] = 1'b0;
					for (int j = 0; j < tbl_count; j++) begin
						used[tbl_label[j]] = 1'b1;
						if (tbl_label[j] > top) top = tbl_label[j];
					end
					if (!used[0]) o.fresh_label = '0;
					else if (top + 1 < n_objects) o.fresh_label = LABEL_W'(top + 1);
					else begin
						for (int j = n_objects - 1; j >= 0; j--)
							if (!used[j]) o.fresh_label = LABEL_W'(j);
					end
				end
			end
			CMD_QUERY: begin
				addressed = 1'b1;
				if (!tbl_current) table_rebuild();
				if (!obj_ok) o.status = STAT_BAD_OBJ;
				else begin
					sl = slot_of(obj_label[r.object_index]);
					if (sl < tbl_count) o.cluster_size = tbl_size[sl];
					else sl = 0;
					o.cluster_slot = LABEL_W'(sl);
				end
			end
			default: ;
		endcase
		if (addressed && obj_ok) o.object_label = obj_label[r.object_index];
		o.cluster_total = COUNT_W'(tbl_count);
		return o;
	endfunction

	// Present one command beat, hold it until taken, then queue its prediction.
	task automatic send_command(cmd_t c, int unsigned obj, int unsigned lab);
		req_t r;
		r.command = c;
		r.object_index = LABEL_W'(obj);
		r.new_label = LABEL_W'(lab);
		do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(label_table_predict(r));
		beats_in++;
		req_valid <= 1'b0;
	endtask

	// Raw beat, used to reach the unknown command codes.
	task automatic send_raw(req_t r);
		@(posedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(label_table_predict(r));
		beats_in++;
		req_valid <= 1'b0;
	endtask

	// Wait until every result is back, then let the block settle.
	task automatic drain();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Set the object count while idle; 0 and values above 64 are clamped.
	task automatic set_objects(int unsigned v);
		int unsigned n;
		drain();
		n = (v == 0) ? 1 : (v > MAX_OBJECTS ? MAX_OBJECTS : v);
		cfg_wdata <= COUNT_W'(v);
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_init(n);
		repeat (3) @(posedge clk);
	endtask

	// Receiver: stall at random, compare each taken beat with the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				beats_out++;
				if (pending_rsp.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					automatic rsp_t e = pending_rsp.pop_front();
					status_seen[rsp.status]++;
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						fail_count++;
					end
					if (rsp.object_label !== e.object_label) begin
						$error("object_label: expected %0d, got %0d",
							e.object_label, rsp.object_label);
						fail_count++;
					end
					if (rsp.cluster_slot !== e.cluster_slot) begin
						$error("cluster_slot: expected %0d, got %0d",
							e.cluster_slot, rsp.cluster_slot);
						fail_count++;
					end
					if (rsp.cluster_size !== e.cluster_size) begin
						$error("cluster_size: expected %0d, got %0d",
							e.cluster_size, rsp.cluster_size);
						fail_count++;
					end
					if (rsp.cluster_total !== e.cluster_total) begin
						$error("cluster_total: expected %0d, got %0d",
							e.cluster_total, rsp.cluster_total);
						fail_count++;
					end
					if (rsp.fresh_label !== e.fresh_label) begin
						$error("fresh_label: expected %0d, got %0d",
							e.fresh_label, rsp.fresh_label);
						fail_count++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles with no beat in either direction.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Directed: extremes of fields, every command, every status, unknown codes.
	task automatic test_directed();
		req_t r;
		send_command(CMD_QUERY, 0, 0);
		send_command(CMD_QUERY, 63, 0);
		send_command(CMD_PROPOSE, 0, 0);
		send_command(CMD_MOVE, 5, 63);
		send_command(CMD_MOVE, 5, 5);
		send_command(CMD_MOVE, 5, 0);
		send_command(CMD_WRITE, 63, 63);
		send_command(CMD_WRITE, 7, 42);
		send_command(CMD_MOVE, 8, 3);
		send_command(CMD_PROPOSE, 0, 0);
		send_command(CMD_REBUILD, 0, 0);
		send_command(CMD_REBUILD, 0, 0);
		for (int k = 5; k < 8; k++) begin
			r.command = CMD_W'(k);
			r.object_index = 6'h3f;
			r.new_label = 6'h2a;
			send_raw(r);
		end
		set_objects(4);
		send_command(CMD_WRITE, 4, 0);
		send_command(CMD_WRITE, 1, 4);
		send_command(CMD_MOVE, 9, 9);
		send_command(CMD_MOVE, 3, 3);
		send_command(CMD_MOVE, 2, 1);
		send_command(CMD_MOVE, 1, 2);
		send_command(CMD_PROPOSE, 0, 0);
		send_command(CMD_MOVE, 0, 3);
		send_command(CMD_PROPOSE, 0, 0);
		send_command(CMD_QUERY, 2, 0);
	endtask

	// Random: mostly legal commands on the configured size, some bad indices.
	task automatic test_random(int count, int unsigned size_cfg);
		int unsigned obj, lab, pick;
		cmd_t c;
		set_objects(size_cfg);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 30) c = CMD_MOVE;
			else if (pick < 55) c = CMD_WRITE;
			else if (pick < 75) c = CMD_QUERY;
			else if (pick < 88) c = CMD_PROPOSE;
			else c = CMD_REBUILD;
			if ($urandom_range(9) == 0) begin
				obj = $urandom_range(63);
				lab = $urandom_range(63);
			end else begin
				obj = $urandom_range(n_objects - 1);
				lab = $urandom_range(n_objects - 1);
			end
			// keep label sets small sometimes so free-label gaps appear
			if ($urandom_range(3) == 0 && n_objects > 3) lab = $urandom_range(2);
			send_command(c, obj, lab);
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) status_seen[i] = 0;
		table_init(MAX_OBJECTS);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// receiver idles more often than sender
		send_idle_pct = 34;
		recv_idle_pct = 69;
		test_directed();
		test_random(120, 64);
		test_random(120, 0);
		test_random(120, 2);

		// the other way round
		send_idle_pct = 69;
		recv_idle_pct = 34;
		test_random(120, 127);
		test_random(120, 7);
		test_random(120, 33);

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(120, 1);
		test_random(120, 16);
		test_random(120, 64);

		drain();
		$display("Covered %0d command beats, %0d result beats over several object counts.",
			beats_in, beats_out);
		$display("Statuses seen: ok %0d, bad object %0d, bad label %0d, stale %0d, no free %0d",
			status_seen[STAT_OK], status_seen[STAT_BAD_OBJ], status_seen[STAT_BAD_LABEL],
			status_seen[STAT_STALE], status_seen[STAT_NO_FREE]);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
